FILE: design/spmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spmv_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ACCUM = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Unpacked binary32 value: significand with hidden bit, unbiased exponent.
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [9:0]  exp;
        logic [23:0] man;
    } t_fp_unp;

    // Control word carried down the datapath.
    typedef struct packed {
        logic accum;
        logic close;
    } t_ctl;

    function automatic t_fp_unp fp_unpack(input logic [31:0] v);
        t_fp_unp u;
        u.sign = v[31];
        u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
        u.zero = (v[30:0] == 31'd0);
        if (v[30:23] == 8'd0) begin
            u.exp = 10'd1 - 10'd127;
            u.man = {1'b0, v[22:0]};
        end else begin
            u.exp = {2'b00, v[30:23]} - 10'd127;
            u.man = {1'b1, v[22:0]};
        end
        return u;
    endfunction

    // Round a value sig * 2^(e - 26) (sig has its leading one at bit 26 or
    // below, the two extra bits plus a sticky in bit 0) to binary32.
    // e is the exponent of bit 26. sig is already normalized unless e is at
    // the subnormal floor.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [26:0] sig);
        logic [26:0]        m;
        logic signed [11:0] ee;
        logic [11:0]        sh;
        logic               st;
        logic [24:0]        r;
        logic               inc;
        m  = sig;
        ee = e;
        st = 1'b0;
        // bring into subnormal range with sticky shifts
        if (ee < -12'sd126) begin
            sh = 12'(-12'sd126 - ee);
            if (sh > 12'd27) sh = 12'd27;
            st = |(m & ((27'd1 << sh) - 27'd1));
            m  = m >> sh;
            ee = -12'sd126;
        end
        st  = st | m[0];
        inc = m[2] & (m[1] | st | m[3]);
        r   = {1'b0, m[26:3]} + {24'd0, inc};
        if (r[24]) begin
            r  = r >> 1;
            ee = ee + 12'sd1;
        end
        if (!r[23]) return {s, 8'd0, r[22:0]};
        if (ee > 12'sd127) return {s, 8'hFF, 23'd0};
        return {s, 8'(ee + 12'sd127), r[22:0]};
    endfunction

endpackage
`default_nettype wire

FILE: design/spmv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/spmv_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-stage binary32 multiplier: 24x24 product registered, then normalize
// and round.
module spmv_mul (
    input  wire         i_clk,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [31:0] o_p
);
    import spmv_pkg::*;

    t_fp_unp            ua, ub;
    logic [47:0]        r_prod;
    logic signed [11:0] r_exp;
    logic               r_sign, r_nan, r_inf, r_zero;

    logic [47:0]        norm;
    logic [5:0]         lz;
    logic signed [11:0] e;
    logic [26:0]        sig;

    assign ua = fp_unpack(i_a);
    assign ub = fp_unpack(i_b);

    // stage 1: significand product and special flags
    always_ff @(posedge i_clk) begin
        r_prod <= 48'(ua.man) * 48'(ub.man);
        r_exp  <= 12'(signed'(ua.exp)) + 12'(signed'(ub.exp));
        r_sign <= ua.sign ^ ub.sign;
        r_nan  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
        r_inf  <= ua.inf | ub.inf;
        r_zero <= ua.zero | ub.zero;
    end

    // stage 2: normalize (product bit 46 weighs 2^exp) and round
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r_prod[i]) lz = 6'(47 - i);
        end
        norm = r_prod << lz;
        e    = r_exp + 12'sd1 - 12'(lz);
        sig  = {norm[47:22], |norm[21:0]};
        if (r_nan)       o_p = CANON_NAN;
        else if (r_inf)  o_p = {r_sign, 8'hFF, 23'd0};
        else if (r_zero) o_p = {r_sign, 31'd0};
        else             o_p = fp_round(r_sign, e, sig);
    end
endmodule
`default_nettype wire

FILE: design/spmv_add.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-stage binary32 adder: operands aligned and registered, then
// add, normalize and round.
module spmv_add (
    input  wire         i_clk,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [31:0] o_s
);
    import spmv_pkg::*;

    t_fp_unp            ua, ub, big, sml;
    logic [9:0]         d;
    logic [27:0]        sm_al;
    logic               swap;

    logic               r_nan, r_inf, r_infs, r_sub, r_sign, r_bz;
    logic signed [11:0] r_exp;
    logic [27:0]        r_bm, r_sm;
    logic               r_zz, r_zs;

    logic [28:0]        sum;
    logic [4:0]         lz;
    logic [28:0]        norm;
    logic signed [11:0] e;

    assign ua = fp_unpack(i_a);
    assign ub = fp_unpack(i_b);

    // stage 1: order operands, align smaller with sticky
    always_comb begin
        // magnitude compare on the biased exponent so negative exponents order right
        swap  = ({ub.exp + 10'd127, ub.man} > {ua.exp + 10'd127, ua.man});
        big   = swap ? ub : ua;
        sml   = swap ? ua : ub;
        d     = big.exp - sml.exp;
        if (d > 10'd27) sm_al = {27'd0, |sml.man};
        else sm_al = ({sml.man, 4'd0} >> d) |
                     {27'd0, |({sml.man, 4'd0} & ((28'd1 << d) - 28'd1))};
    end

    always_ff @(posedge i_clk) begin
        r_nan  <= ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign != ub.sign));
        r_inf  <= ua.inf | ub.inf;
        r_infs <= ua.inf ? ua.sign : ub.sign;
        r_sub  <= ua.sign ^ ub.sign;
        r_sign <= big.sign;
        r_exp  <= 12'(signed'(big.exp));
        r_bm   <= {big.man, 4'd0};
        r_sm   <= sm_al;
        r_bz   <= big.zero;
        r_zz   <= ua.zero & ub.zero;
        r_zs   <= ua.sign & ub.sign;
    end

    // stage 2: add or subtract, normalize, round
    always_comb begin
        sum = r_sub ? ({1'b0, r_bm} - {1'b0, r_sm}) : ({1'b0, r_bm} + {1'b0, r_sm});
        lz  = 5'd0;
        for (int i = 0; i < 29; i++) begin
            if (sum[i]) lz = 5'(28 - i);
        end
        // sum bit 27 weighs 2^r_exp; keep exponent at floor for subnormals
        e = r_exp + 12'sd1 - 12'(lz);
        if (e < -12'sd126) begin
            norm = sum << 5'(r_exp + 12'sd127);
            e    = -12'sd126;
        end else begin
            norm = sum << lz;
        end
        if (r_nan)                 o_s = CANON_NAN;
        else if (r_inf)            o_s = {r_infs, 8'hFF, 23'd0};
        else if (r_zz)             o_s = {r_zs, 31'd0};
        else if (sum == 29'd0)     o_s = 32'd0;
        else if (r_bz)             o_s = {r_sign, 31'd0};
        else o_s = fp_round(r_sign, e, {norm[28:3], |norm[2:0]});
    end
endmodule
`default_nettype wire

FILE: design/csr_sparse_matrix_vector_product_core.sv
`timescale 1ns / 1ps
`default_nettype none
// CSR sparse matrix times dense vector, binary32.
// Input stream (s_axis): tuser = op (0 write vector element, 1 accumulate
// nonzero, 2 close row, 3 no effect); tdata = element_index, element_value.
// Output stream (m_axis): one transaction per close, tdata = row_sum,
// row_number.
// Load the vector with op 0 first, then stream each row's nonzeros (op 1)
// followed by op 2. An op 1 item passes through four register stages:
// vector RAM read (1), multiply (2, the second ends in a product register),
// adder alignment (1); the running sum is written as the item leaves the
// fourth stage. The add depends on the previous sum, so an op 1 or op 2 item
// is accepted only when no sum update is in flight; op 0 and op 3 items are
// always ready. A close passes the same stages and then loads the row
// result into the output, which has one register stage; while it is full
// and the receiver stalls, a close is held off, other items flow. Reset
// clears the running sum to +0 and the row number to 0; vector RAM
// contents are undefined until written.
module csr_sparse_matrix_vector_product_core #(
    parameter int VECTOR_DEPTH = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // element_index[11:0], element_value[43:12], zeros
    input  wire  [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // row_sum[31:0], row_number[47:32]
);
    import spmv_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);

    logic        acc;
    t_op         op;
    logic [11:0] idx;
    logic [31:0] val;
    logic        in_range;

    // pipeline control: s1 = RAM read, s2/s3 = mul, s4 = add align
    t_ctl        r_c1, r_c2, r_c3, r_c4;
    logic [31:0] r_v1;
    logic        r_ok1;
    logic [31:0] rdata, prod, sum;
    logic [31:0] r_prod;
    logic [31:0] r_sum;
    logic [15:0] r_row;
    logic        r_oval;
    logic [47:0] r_odata;
    logic        busy;

    assign op       = t_op'(s_axis_tuser);
    assign idx      = s_axis_tdata[11:0];
    assign val      = s_axis_tdata[43:12];
    assign in_range = (32'(idx) < VECTOR_DEPTH);

    // hold accumulate/close while any sum update is in flight; close also
    // waits for a free output register
    assign busy = r_c1.accum | r_c2.accum | r_c3.accum |
                  r_c1.close | r_c2.close | r_c3.close;
    always_comb begin
        unique case (op)
            OP_ACCUM: s_axis_tready = !busy;
            OP_CLOSE: s_axis_tready = !busy && !r_oval && !r_c4.close;
            default:  s_axis_tready = 1'b1;
        endcase
    end
    assign acc = s_axis_tvalid && s_axis_tready;

    spmv_ram #(.WIDTH(32), .DEPTH(VECTOR_DEPTH)) u_vec (
        .i_clk  (i_clk),
        .i_we   (acc && op == OP_WRITE && in_range),
        .i_waddr(AW'(idx)),
        .i_wdata(val),
        .i_raddr(AW'(idx)),
        .o_rdata(rdata)
    );

    spmv_mul u_mul (
        .i_clk(i_clk),
        .i_a  (r_v1),
        .i_b  (r_ok1 ? rdata : 32'd0),
        .o_p  (prod)
    );

    spmv_add u_add (
        .i_clk(i_clk),
        .i_a  (r_sum),
        .i_b  (r_prod),
        .o_s  (sum)
    );

    // control pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
        end else begin
            r_c1 <= '{accum: acc && op == OP_ACCUM, close: acc && op == OP_CLOSE};
            r_c2 <= r_c1; r_c3 <= r_c2; r_c4 <= r_c3;
        end
    end

    // payload alignment with the RAM read, product register
    always_ff @(posedge i_clk) begin
        r_v1   <= val;
        r_ok1  <= in_range;
        r_prod <= prod;
    end

    // running sum, row counter, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 32'd0;
            r_row  <= 16'd0;
            r_oval <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            if (r_c4.accum) r_sum <= sum;
            if (r_c4.close) begin
                r_odata <= {r_row, r_sum};
                r_oval  <= 1'b1;
                r_row   <= r_row + 16'd1;
                r_sum   <= 32'd0;
            end
        end
    end
    // output channel
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_c4.accum && r_c4.close)) else $error("accum and close together");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c1.accum |-> !(r_c2.accum || r_c3.accum || r_c4.accum))
        else $error("overlapping sum updates");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c4.close |-> !r_oval || (m_axis_tvalid && m_axis_tready))
        else $error("result overwritten");
`endif
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import spmv_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam real TWO_M149     = 2.0 ** (-149);

    typedef struct {
        t_op         op;
        logic [11:0] index;
        logic [31:0] value;
        bit          drain;   // sender waits here until all row sums are back
    } t_item;

    typedef struct {
        logic [31:0] sum;
        logic [15:0] row;
    } t_row_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // element_index[11:0], element_value[43:12], zeros
    logic [1:0]  s_axis_tuser = '0;   // op[1:0]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;        // row_sum[31:0], row_number[47:32]

    csr_sparse_matrix_vector_product_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    t_item       pending_items[$];
    t_row_result row_results[$];
    logic [11:0] loaded_cols[$];
    bit          col_loaded[4096];

    // Predictor state
    logic [31:0] vec_mem[4096];
    logic [31:0] acc_sum = '0;
    logic [15:0] row_idx = '0;

    int  accepted_cnt = 0;
    int  issued_cnt = 0;
    int  result_cnt = 0;
    int  cycle_cnt = 0;
    int  errors = 0;
    bit  stim_done = 1'b0;

    // binary32 bits to real, exact
    function automatic real fp32_to_real(input logic [31:0] b);
        logic [63:0] d;
        real         r;
        if (b[30:23] == 8'h00) begin
            r = real'(b[22:0]) * TWO_M149;
            return b[31] ? -r : r;
        end
        if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, b[22:0], 29'd0};
        else d = {b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0};
        return $bitstoreal(d);
    endfunction

    // real to binary32 bits, round to nearest even, NaN made canonical
    function automatic logic [31:0] real_to_fp32(input real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] v;
        logic        s;
        int          e;
        int          sh;
        d = $realtobits(x);
        s = d[63];
        if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {s, 8'hFF, 23'd0};
        if (d[62:52] == 11'h000) return {s, 31'd0};
        e   = int'(d[62:52]) - 1023;
        if (e > 127) return {s, 8'hFF, 23'd0};
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) sh = 60;
        r    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && r[0])) r = r + 64'd1;
        if (e >= -126) v = (64'(e + 127) << 23) + r - 64'h80_0000;
        else v = r;
        if (v >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
        return {s, v[30:0]};
    endfunction

    // Apply one accepted transaction to the predicted matrix-vector state
    task automatic predict_item(input t_op op, input logic [11:0] index,
                                input logic [31:0] value);
        logic [31:0] prod;
        t_row_result res;
        case (op)
            OP_WRITE: vec_mem[index] = value;
            OP_ACCUM: begin
                prod    = real_to_fp32(fp32_to_real(value) * fp32_to_real(vec_mem[index]));
                acc_sum = real_to_fp32(fp32_to_real(acc_sum) + fp32_to_real(prod));
            end
            OP_CLOSE: begin
                res.sum = acc_sum;
                res.row = row_idx;
                row_results.push_back(res);
                acc_sum = '0;
                row_idx = row_idx + 16'd1;
            end
            default: ;
        endcase
    endtask

    // Accept and check at the rising edge
    always @(posedge i_clk) begin
        t_row_result exp_res;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_item(t_op'(s_axis_tuser), s_axis_tdata[11:0], s_axis_tdata[43:12]);
            accepted_cnt = accepted_cnt + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_cnt = result_cnt + 1;
            if (row_results.size() == 0) begin
                $display("%0t: unexpected row transaction, actual sum %h row %0d", $time,
                         m_axis_tdata[31:0], m_axis_tdata[47:32]);
                errors = errors + 1;
            end else begin
                exp_res = row_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_res.sum) begin
                    $display("%0t: row_sum mismatch, expected %h actual %h", $time,
                             exp_res.sum, m_axis_tdata[31:0]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[47:32] !== exp_res.row) begin
                    $display("%0t: row_number mismatch, expected %0d actual %0d", $time,
                             exp_res.row, m_axis_tdata[47:32]);
                    errors = errors + 1;
                end
            end
        end
    end

    // Input driver: one item per transaction, random gaps with gap-free bursts
    int  tx_gap = 0;
    bit  tx_busy = 1'b0;
    bit  tx_burst = 1'b0;
    always @(negedge i_clk) begin
        t_item it;
        if (tx_busy && accepted_cnt == issued_cnt) tx_busy = 1'b0;
        if (i_rst_n && !tx_busy) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
            end else if (pending_items.size() > 0) begin
                if (pending_items[0].drain) begin
                    if (row_results.size() == 0) void'(pending_items.pop_front());
                end else begin
                    it = pending_items.pop_front();
                    s_axis_tuser <= it.op;
                    s_axis_tdata <= {4'd0, it.value, it.index};
                    issued_cnt = issued_cnt + 1;
                    tx_busy = 1'b1;
                    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
                end
            end
        end
        s_axis_tvalid <= tx_busy;
    end

    // Output receiver: random stalls after each row transaction, one long hold-off
    int  rx_seen = 0;
    int  rx_stall = 0;
    int  rx_hold = 0;
    bit  rx_held = 1'b0;
    always @(negedge i_clk) begin
        if (rx_seen != result_cnt) begin
            rx_seen  = result_cnt;
            rx_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end
        if (!rx_held && result_cnt == 15) begin
            rx_held = 1'b1;
            rx_hold = 300;
        end
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    task automatic add_item(input t_op op, input logic [11:0] index, input logic [31:0] value);
        t_item it;
        it.op    = op;
        it.index = index;
        it.value = value;
        it.drain = 1'b0;
        pending_items.push_back(it);
        if (op == OP_WRITE && !col_loaded[index]) begin
            col_loaded[index] = 1'b1;
            loaded_cols.push_back(index);
        end
    endtask

    task automatic add_drain();
        t_item it;
        it.op    = OP_NONE;
        it.index = '0;
        it.value = '0;
        it.drain = 1'b1;
        pending_items.push_back(it);
    endtask

    // Mostly moderate magnitudes so sums stay meaningful, some raw bit patterns
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return {$urandom_range(0, 1) == 1, 8'(0), 23'($urandom)};
            3:       return {$urandom_range(0, 1) == 1, 31'd0};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)),
                             23'($urandom)};
        endcase
    endfunction

    function automatic logic [11:0] pick_col();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    initial begin
        int n;
        int k;
        // Directed: index extremes, special values, every op
        add_item(OP_WRITE, 12'd0,    32'h3F80_0000);   // 1.0
        add_item(OP_WRITE, 12'd4095, 32'h7F7F_FFFF);   // max normal
        add_item(OP_WRITE, 12'd1,    32'h8000_0000);   // -0
        add_item(OP_WRITE, 12'd2,    32'h0000_0001);   // min subnormal
        add_item(OP_WRITE, 12'd3,    32'h7F80_0000);   // +inf
        add_item(OP_WRITE, 12'd4,    32'hFFC1_2345);   // NaN
        add_item(OP_CLOSE, 12'd0,    32'd0);           // empty row gives +0
        add_item(OP_ACCUM, 12'd1,    32'h3F80_0000);   // products all -0
        add_item(OP_ACCUM, 12'd0,    32'h8000_0000);
        add_item(OP_CLOSE, 12'd0,    32'd0);
        add_item(OP_ACCUM, 12'd4095, 32'h4000_0000);   // overflow to inf
        add_item(OP_ACCUM, 12'd2,    32'h3F00_0000);   // subnormal tie
        add_item(OP_CLOSE, 12'd0,    32'd0);
        add_item(OP_ACCUM, 12'd3,    32'h0000_0000);   // inf * 0 gives NaN
        add_item(OP_ACCUM, 12'd0,    32'h3F80_0000);
        add_item(OP_NONE,  12'hFFF,  32'hFFFF_FFFF);   // unused op
        add_item(OP_CLOSE, 12'hFFF,  32'hFFFF_FFFF);
        add_item(OP_ACCUM, 12'd4,    32'h3F80_0000);   // NaN input held
        add_item(OP_ACCUM, 12'd0,    32'h4040_0000);
        add_item(OP_CLOSE, 12'd0,    32'd0);
        add_item(OP_ACCUM, 12'd4095, 32'hFF7F_FFFF);   // -inf then +inf
        add_item(OP_ACCUM, 12'd3,    32'h3F80_0000);
        add_item(OP_CLOSE, 12'd0,    32'd0);
        add_drain();
        // Random: vector loads and rows of nonzeros interleaved, with noise mixed in
        n = 0;
        while (n < 430) begin
            k = $urandom_range(0, 15);
            if (k < 3) begin
                add_item(OP_WRITE, 12'($urandom), pick_value());
                n = n + 1;
            end else if (k == 3) begin
                add_item(OP_NONE, 12'($urandom), $urandom);
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    add_item(OP_ACCUM, pick_col(), pick_value());
                    n = n + 1;
                end
                add_item(OP_CLOSE, 12'($urandom), $urandom);
                n = n + 1;
            end
            if (n > 200 && n < 210) add_drain();
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && accepted_cnt == issued_cnt && !s_axis_tvalid);
        wait (row_results.size() == 0);
        repeat (20) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // End of run or timeout
    always @(posedge i_clk) begin
        if (stim_done) begin
            if (errors == 0 && row_results.size() == 0)
                $display("csr_sparse_matrix_vector_product_core test passed");
            else
                $display("csr_sparse_matrix_vector_product_core test failed");
            $finish;
        end else if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("csr_sparse_matrix_vector_product_core test failed");
            $finish;
        end
    end

endmodule
